[rtl/integrity_tree_metadata_addr_gen_unit_assert.svh]
// Assertion macros for the integrity tree metadata address generator checks.
`ifndef INTEGRITY_TREE_METADATA_ADDR_GEN_UNIT_ASSERT_SVH
`define INTEGRITY_TREE_METADATA_ADDR_GEN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ITMAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ITMAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/itmag_pkg.sv]
// Shared types, codes and defaults for the integrity tree metadata address generator.
`default_nettype none

package itmag_pkg;

  localparam int FIELD_BITS     = 48;
  localparam int KIND_BITS      = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int SLOT_BITS      = 3;

  localparam int BLOCK_BYTES_DEF = 64;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int MAC_BYTES_DEF   = 8;
  localparam int TREE_ARITY_DEF  = 8;
  localparam int ADDR_BITS_DEF   = 48;

  // Metadata kinds
  localparam logic [KIND_BITS-1:0] KIND_MAC     = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_COUNTER = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_NODE    = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_ROOT    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DATA_START      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DATA_END        = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAC_BASE        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNTER_BASE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_NODE_BASE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_NODE_BASE = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_ADDRESS    = 3'd6;

  // Position within one run: MAC first, then counter and tree levels
  localparam logic [SLOT_BITS-1:0] SLOT_MAC     = 3'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_COUNTER = 3'd1;
  localparam logic [SLOT_BITS-1:0] SLOT_FINAL   = 3'd4;

  typedef struct packed {
    logic [FIELD_BITS-1:0] data_start;
    logic [FIELD_BITS-1:0] data_end;
    logic [FIELD_BITS-1:0] mac_base;
    logic [FIELD_BITS-1:0] counter_base;
    logic [FIELD_BITS-1:0] lower_node_base;
    logic [FIELD_BITS-1:0] upper_node_base;
    logic [FIELD_BITS-1:0] root_address;
  } cfg_regs_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] meta_address;
    logic [KIND_BITS-1:0]  meta_kind;
    logic                  out_of_range;
    logic                  last_of_run;
  } result_t;

endpackage

`default_nettype wire

[rtl/itmag_ifs.sv]
// Stream and configuration interfaces of the metadata address generator.
`default_nettype none

interface itmag_access_if;
  logic                             valid;
  logic                             ready;
  logic [itmag_pkg::FIELD_BITS-1:0] data_address;
  modport source (output valid, output data_address, input ready);
  modport sink (input valid, input data_address, output ready);
endinterface

interface itmag_fetch_if;
  logic                             valid;
  logic                             ready;
  logic [itmag_pkg::FIELD_BITS-1:0] meta_address;
  logic [itmag_pkg::KIND_BITS-1:0]  meta_kind;
  logic                             out_of_range;
  logic                             last_of_run;
  modport source (output valid, output meta_address, output meta_kind,
                  output out_of_range, output last_of_run, input ready);
  modport sink (input valid, input meta_address, input meta_kind,
                input out_of_range, input last_of_run, output ready);
endinterface

interface itmag_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [itmag_pkg::CFG_INDEX_BITS-1:0] index;
  logic [itmag_pkg::FIELD_BITS-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/integrity_tree_metadata_addr_gen_unit.sv]
// Top level of the integrity tree metadata address generator.
// For each accepted data address the unit emits a run of one to five metadata
// block addresses: the MAC block, the counter block, the tree nodes above it and
// finally the root, with last_of_run on the final one. An address outside
// [data_start, data_end) yields a single out_of_range result. One result leaves
// per cycle, unless the receiver stalls, from a single result register fed by
// one step of address logic, so the unit works on one data address at a time;
// the next data address is taken in the cycle its last result is produced, even
// while that result still waits in the output register. Configuration writes are
// taken every cycle. BLOCK_BYTES, PAGE_BYTES, MAC_BYTES and TREE_ARITY must be
// powers of two; the divisions by them are shifts.
`default_nettype none

module integrity_tree_metadata_addr_gen_unit #(
  parameter int BLOCK_BYTES = itmag_pkg::BLOCK_BYTES_DEF,
  parameter int PAGE_BYTES  = itmag_pkg::PAGE_BYTES_DEF,
  parameter int MAC_BYTES   = itmag_pkg::MAC_BYTES_DEF,
  parameter int TREE_ARITY  = itmag_pkg::TREE_ARITY_DEF,
  parameter int ADDR_BITS   = itmag_pkg::ADDR_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst,
  itmag_cfg_if.sink     cfg,
  itmag_access_if.sink  access,
  itmag_fetch_if.source fetch
);

  localparam int W = (ADDR_BITS > itmag_pkg::FIELD_BITS) ? ADDR_BITS : itmag_pkg::FIELD_BITS;

  itmag_pkg::cfg_regs_t                regs;
  itmag_pkg::result_t                  res;
  itmag_pkg::result_t                  out_res;
  logic                                out_valid;
  logic                                work_valid;
  logic [itmag_pkg::SLOT_BITS-1:0]     work_slot;
  logic [itmag_pkg::FIELD_BITS-1:0]    work_a;
  logic [W-1:0]                        work_cur;
  logic [W-1:0]                        cur_next;
  logic                                advance;
  logic                                acc_fire;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        itmag_pkg::REG_DATA_START:      regs.data_start      <= cfg.data;
        itmag_pkg::REG_DATA_END:        regs.data_end        <= cfg.data;
        itmag_pkg::REG_MAC_BASE:        regs.mac_base        <= cfg.data;
        itmag_pkg::REG_COUNTER_BASE:    regs.counter_base    <= cfg.data;
        itmag_pkg::REG_LOWER_NODE_BASE: regs.lower_node_base <= cfg.data;
        itmag_pkg::REG_UPPER_NODE_BASE: regs.upper_node_base <= cfg.data;
        itmag_pkg::REG_ROOT_ADDRESS:    regs.root_address    <= cfg.data;
        default: ;
      endcase
    end
  end

  itmag_step #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .MAC_BYTES   (MAC_BYTES),
    .TREE_ARITY  (TREE_ARITY),
    .ADDR_BITS   (ADDR_BITS)
  ) u_step (
    .regs         (regs),
    .slot         (work_slot),
    .data_address (work_a),
    .cur          (work_cur),
    .res          (res),
    .cur_next     (cur_next)
  );

  // Produce a result whenever the output register is free or being drained
  assign advance      = work_valid && (!out_valid || fetch.ready);
  assign access.ready = !work_valid || (advance && res.last_of_run);
  assign acc_fire     = access.valid && access.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_slot  <= itmag_pkg::SLOT_MAC;
    end else if (acc_fire) begin
      work_valid <= 1'b1;
      work_slot  <= itmag_pkg::SLOT_MAC;
    end else if (advance && res.last_of_run) begin
      work_valid <= 1'b0;
    end else if (advance) begin
      work_slot <= work_slot + itmag_pkg::SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      work_a <= access.data_address;
    end
    if (advance) begin
      work_cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (fetch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign fetch.valid        = out_valid;
  assign fetch.meta_address = out_res.meta_address;
  assign fetch.meta_kind    = out_res.meta_kind;
  assign fetch.out_of_range = out_res.out_of_range;
  assign fetch.last_of_run  = out_res.last_of_run;

endmodule

`default_nettype wire

[rtl/itmag_step.sv]
// One step of a run: the result for the current slot and the next tree address.
`default_nettype none

module itmag_step #(
  parameter int BLOCK_BYTES = itmag_pkg::BLOCK_BYTES_DEF,
  parameter int PAGE_BYTES  = itmag_pkg::PAGE_BYTES_DEF,
  parameter int MAC_BYTES   = itmag_pkg::MAC_BYTES_DEF,
  parameter int TREE_ARITY  = itmag_pkg::TREE_ARITY_DEF,
  parameter int ADDR_BITS   = itmag_pkg::ADDR_BITS_DEF,
  localparam int W = (ADDR_BITS > itmag_pkg::FIELD_BITS) ? ADDR_BITS : itmag_pkg::FIELD_BITS
) (
  input  wire itmag_pkg::cfg_regs_t          regs,
  input  wire [itmag_pkg::SLOT_BITS-1:0]     slot,
  input  wire [itmag_pkg::FIELD_BITS-1:0]    data_address,
  input  wire [W-1:0]                        cur,
  output itmag_pkg::result_t                 res,
  output logic [W-1:0]                       cur_next
);

  localparam int LB = $clog2(BLOCK_BYTES);
  localparam int LP = $clog2(PAGE_BYTES);
  localparam int LM = $clog2(MAC_BYTES);
  localparam int LA = $clog2(TREE_ARITY);
  localparam int FB = itmag_pkg::FIELD_BITS;
  localparam logic [W-1:0] AMASK = {W{1'b1}} >> (W - ADDR_BITS);
  localparam logic [W-1:0] BMASK = ~W'(BLOCK_BYTES - 1);

  logic [W-1:0] a_w;
  logic [W-1:0] mac;
  logic [W-1:0] ctr;
  logic [W-1:0] eff;
  logic [W-1:0] root_w;
  logic [W-1:0] cbase_w;
  logic [W-1:0] lbase_w;
  logic [W-1:0] ubase_w;
  logic [W-1:0] base;
  logic [W-1:0] pbase;
  logic [W-1:0] parent;
  logic         in_rng;
  logic         is_root;
  logic         in_lvl;

  assign a_w     = W'(data_address);
  assign root_w  = W'(regs.root_address);
  assign cbase_w = W'(regs.counter_base);
  assign lbase_w = W'(regs.lower_node_base);
  assign ubase_w = W'(regs.upper_node_base);

  assign in_rng = (data_address >= regs.data_start) && (data_address < regs.data_end);
  assign mac    = (W'(regs.mac_base) + ((a_w >> LB) << LM)) & AMASK & BMASK;
  assign ctr    = (cbase_w + ((a_w >> LP) << LB)) & AMASK;

  // The final slot always shows the root
  assign eff     = (slot == itmag_pkg::SLOT_FINAL) ? root_w : cur;
  assign is_root = (eff == root_w);

  always_comb begin
    in_lvl = 1'b1;
    base   = cbase_w;
    pbase  = lbase_w;
    if ((eff >= cbase_w) && (eff < lbase_w)) begin
      base  = cbase_w;
      pbase = lbase_w;
    end else if ((eff >= lbase_w) && (eff < ubase_w)) begin
      base  = lbase_w;
      pbase = ubase_w;
    end else if ((eff >= ubase_w) && (eff < root_w)) begin
      base  = ubase_w;
      pbase = root_w;
    end else begin
      in_lvl = 1'b0;
    end
  end

  assign parent = (pbase + (((eff - base) >> (LB + LA)) << LB)) & AMASK;

  always_comb begin
    res      = '0;
    cur_next = ctr;
    if (slot == itmag_pkg::SLOT_MAC) begin
      res.meta_address = in_rng ? mac[FB-1:0] : '0;
      res.meta_kind    = itmag_pkg::KIND_MAC;
      res.out_of_range = !in_rng;
      res.last_of_run  = !in_rng;
      cur_next         = ctr;
    end else begin
      res.meta_address = eff[FB-1:0];
      res.out_of_range = 1'b0;
      res.last_of_run  = is_root;
      if (is_root) begin
        res.meta_kind = itmag_pkg::KIND_ROOT;
      end else if (slot == itmag_pkg::SLOT_COUNTER) begin
        res.meta_kind = itmag_pkg::KIND_COUNTER;
      end else begin
        res.meta_kind = itmag_pkg::KIND_NODE;
      end
      // Drop to the root when the node sits in no level region
      cur_next = in_lvl ? parent : root_w;
    end
  end

endmodule

`default_nettype wire

[rtl/itmag_checker.sv]
// Port-level checks on the metadata address generator result stream, bound to the top.
`default_nettype none

`include "integrity_tree_metadata_addr_gen_unit_assert.svh"

module itmag_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             fetch_valid,
  input wire                             fetch_ready,
  input wire [itmag_pkg::FIELD_BITS-1:0] meta_address,
  input wire [itmag_pkg::KIND_BITS-1:0]  meta_kind,
  input wire                             out_of_range,
  input wire                             last_of_run
);

  `ITMAG_ASSERT_NEXT(a_valid_hold, fetch_valid && !fetch_ready, fetch_valid, "result valid dropped while stalled")
  `ITMAG_ASSERT_NEXT(a_payload_hold, fetch_valid && !fetch_ready, $stable(meta_address) && $stable(meta_kind) && $stable(last_of_run), "result changed while stalled")
  `ITMAG_ASSERT_NOW(a_oor_single, fetch_valid && out_of_range, last_of_run && (meta_kind == itmag_pkg::KIND_MAC) && (meta_address == '0), "out of range result malformed")
  `ITMAG_ASSERT_NOW(a_root_ends, fetch_valid && !out_of_range, (meta_kind == itmag_pkg::KIND_ROOT) == last_of_run, "run end and root kind disagree")

endmodule

bind integrity_tree_metadata_addr_gen_unit itmag_checker u_itmag_checker (
  .clk          (clk),
  .rst          (rst),
  .fetch_valid  (fetch.valid),
  .fetch_ready  (fetch.ready),
  .meta_address (fetch.meta_address),
  .meta_kind    (fetch.meta_kind),
  .out_of_range (fetch.out_of_range),
  .last_of_run  (fetch.last_of_run)
);

`default_nettype wire

[test/integrity_tree_metadata_addr_gen_unit_tb.sv]
// Self-checking testbench for the integrity tree metadata address generator.
module integrity_tree_metadata_addr_gen_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [itmag_pkg::FIELD_BITS-1:0] addr_t;
  typedef logic [itmag_pkg::CFG_INDEX_BITS-1:0] reg_idx_t;
  typedef logic [itmag_pkg::KIND_BITS-1:0] kind_t;

  localparam addr_t BLK      = itmag_pkg::FIELD_BITS'(itmag_pkg::BLOCK_BYTES_DEF);
  localparam addr_t PAGE     = itmag_pkg::FIELD_BITS'(itmag_pkg::PAGE_BYTES_DEF);
  localparam addr_t MACB     = itmag_pkg::FIELD_BITS'(itmag_pkg::MAC_BYTES_DEF);
  localparam addr_t ARITY    = itmag_pkg::FIELD_BITS'(itmag_pkg::TREE_ARITY_DEF);
  localparam addr_t ALL_ONES = '1;

  // Index past the last register; the unit must ignore writes to it
  localparam reg_idx_t REG_SPARE = 3'd7;

  localparam int RANDOM_ITEMS  = 189;
  localparam int SETTLE_CYCLES = 10;
  localparam int NUM_PRESETS   = 4;

  typedef struct {
    int                 preset;
    addr_t              addr;
    bit                 typed;
    itmag_pkg::result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  itmag_cfg_if    cfg_bus ();
  itmag_access_if access_bus ();
  itmag_fetch_if  fetch_bus ();

  integrity_tree_metadata_addr_gen_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .access (access_bus),
    .fetch  (fetch_bus)
  );

  itmag_pkg::cfg_regs_t regs;      // register contents as the unit should hold them
  itmag_pkg::cfg_regs_t presets[NUM_PRESETS];
  itmag_pkg::result_t   fetch_due[$];  // metadata fetches still owed by the unit
  stim_row_t            stim_rows[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int phases       = 0;
  bit quiet        = 1'b0;

  // Append one owed fetch at the tail of the queue
  function automatic void owe_fetch(input itmag_pkg::result_t r);
    fetch_due = {fetch_due, r};
  endfunction

  function automatic addr_t rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 1) v = v >> $urandom_range(1, 47);
    return v[itmag_pkg::FIELD_BITS-1:0];
  endfunction

  function automatic addr_t wild48();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ALL_ONES;
      default: return rand48();
    endcase
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic itmag_pkg::result_t meta_result(input addr_t a, input kind_t k,
                                                     input logic last);
    itmag_pkg::result_t r;
    r.meta_address = a;
    r.meta_kind    = k;
    r.out_of_range = 1'b0;
    r.last_of_run  = last;
    return r;
  endfunction

  function automatic itmag_pkg::result_t oor_result();
    itmag_pkg::result_t r;
    r.meta_address = '0;
    r.meta_kind    = itmag_pkg::KIND_MAC;
    r.out_of_range = 1'b1;
    r.last_of_run  = 1'b1;
    return r;
  endfunction

  function automatic itmag_pkg::cfg_regs_t make_regs(input addr_t ds, input addr_t de,
                                                     input addr_t mb, input addr_t cb,
                                                     input addr_t lb, input addr_t ub,
                                                     input addr_t rt);
    itmag_pkg::cfg_regs_t r;
    r.data_start      = ds;
    r.data_end        = de;
    r.mac_base        = mb;
    r.counter_base    = cb;
    r.lower_node_base = lb;
    r.upper_node_base = ub;
    r.root_address    = rt;
    return r;
  endfunction

  function automatic stim_row_t row(input int p, input addr_t a, input bit typed);
    stim_row_t s;
    s.preset = p;
    s.addr   = a;
    s.typed  = typed;
    s.want   = typed ? oor_result() : '0;
    return s;
  endfunction

  function automatic void add_row(input int p, input addr_t a, input bit typed);
    stim_rows = {stim_rows, row(p, a, typed)};
  endfunction

  function automatic bit in_span(input addr_t a, input addr_t lo, input addr_t hi);
    return a >= lo && a < hi;
  endfunction

  // Queue the run of metadata fetches the unit owes for one data address
  function automatic void predict_fetches(input addr_t addr);
    addr_t mac, cur, base, pbase;
    bit    is_root, found;
    int    slot;
    if (!in_span(addr, regs.data_start, regs.data_end)) begin
      owe_fetch(oor_result());
      return;
    end
    mac = regs.mac_base + (addr / BLK) * MACB;
    mac = mac - (mac % BLK);
    owe_fetch(meta_result(mac, itmag_pkg::KIND_MAC, 1'b0));
    cur = regs.counter_base + (addr / PAGE) * BLK;
    for (slot = itmag_pkg::SLOT_COUNTER; slot <= itmag_pkg::SLOT_FINAL; slot++) begin
      if (slot == itmag_pkg::SLOT_FINAL) cur = regs.root_address;
      is_root = (cur == regs.root_address);
      owe_fetch(meta_result(cur,
          is_root ? itmag_pkg::KIND_ROOT :
          (slot == itmag_pkg::SLOT_COUNTER ? itmag_pkg::KIND_COUNTER : itmag_pkg::KIND_NODE),
          is_root));
      if (is_root) return;
      found = 1'b1;
      if (in_span(cur, regs.counter_base, regs.lower_node_base)) begin
        base  = regs.counter_base;
        pbase = regs.lower_node_base;
      end else if (in_span(cur, regs.lower_node_base, regs.upper_node_base)) begin
        base  = regs.lower_node_base;
        pbase = regs.upper_node_base;
      end else if (in_span(cur, regs.upper_node_base, regs.root_address)) begin
        base  = regs.upper_node_base;
        pbase = regs.root_address;
      end else begin
        found = 1'b0;
      end
      // A node outside every level goes straight to the root
      if (found) cur = pbase + ((cur - base) / BLK / ARITY) * BLK;
      else cur = regs.root_address;
    end
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input addr_t v);
    case (idx)
      itmag_pkg::REG_DATA_START:      regs.data_start      = v;
      itmag_pkg::REG_DATA_END:        regs.data_end        = v;
      itmag_pkg::REG_MAC_BASE:        regs.mac_base        = v;
      itmag_pkg::REG_COUNTER_BASE:    regs.counter_base    = v;
      itmag_pkg::REG_LOWER_NODE_BASE: regs.lower_node_base = v;
      itmag_pkg::REG_UPPER_NODE_BASE: regs.upper_node_base = v;
      itmag_pkg::REG_ROOT_ADDRESS:    regs.root_address    = v;
      default: ;
    endcase
  endfunction

  // Well-formed tree layouts most of the time, wild register values otherwise
  function automatic itmag_pkg::cfg_regs_t random_layout();
    itmag_pkg::cfg_regs_t r;
    addr_t                span, blocks;
    int                   mode;
    mode = $urandom_range(0, 9);
    if (mode >= 8) begin
      return make_regs(wild48(), wild48(), wild48(), wild48(), wild48(), wild48(), wild48());
    end
    r.data_start = ($urandom_range(0, 3) == 0) ? (rand48() & ~(PAGE - 1)) : '0;
    span = addr_t'(1) << $urandom_range(12, 26);
    if ($urandom_range(0, 7) == 0) span = addr_t'(1) << $urandom_range(27, 40);
    r.data_end        = r.data_start + span;
    r.mac_base        = r.data_end;
    r.counter_base    = r.mac_base + (span / BLK) * MACB + BLK;
    blocks            = r.data_end / PAGE + 1;
    r.lower_node_base = r.counter_base + blocks * BLK;
    r.upper_node_base = r.lower_node_base + (blocks / ARITY + 1) * BLK;
    r.root_address    = r.upper_node_base + (blocks / (ARITY * ARITY) + 1) * BLK;
    case (mode)
      0: r.upper_node_base = r.lower_node_base;
      1: r.root_address = r.counter_base + ((r.data_start + span / 2) / PAGE) * BLK;
      2: r.lower_node_base = r.counter_base;
      default: ;
    endcase
    return r;
  endfunction

  function automatic addr_t pick_addr();
    int    r;
    addr_t span;
    r = $urandom_range(0, 99);
    span = regs.data_end - regs.data_start;
    if (regs.data_end > regs.data_start) begin
      if (r < 70) return regs.data_start + rand48() % span;
      if (r < 85) begin
        case ($urandom_range(0, 3))
          0: return regs.data_start;
          1: return regs.data_end - 1;
          2: return regs.data_end;
          default: return regs.data_start - 1;
        endcase
      end
    end
    return rand48();
  endfunction

  // Present one data address and hold it until the unit takes it
  task automatic send_access(input addr_t addr, input bit typed,
                             input itmag_pkg::result_t want);
    int gap;
    gap = pick_gap(quiet);
    if (gap != 0) begin
      access_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    access_bus.valid        <= 1'b1;
    access_bus.data_address <= addr;
    do @(posedge clk); while (!access_bus.ready);
    if (typed) owe_fetch(want);
    else predict_fetches(addr);
    items_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input addr_t v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_reg(idx, v);
  endtask

  task automatic program_regs(input itmag_pkg::cfg_regs_t r);
    bit    spare_first;
    addr_t junk;
    spare_first = $urandom_range(0, 1);
    junk = rand48();
    if (spare_first) write_reg(REG_SPARE, junk);
    write_reg(itmag_pkg::REG_DATA_START, r.data_start);
    write_reg(itmag_pkg::REG_DATA_END, r.data_end);
    write_reg(itmag_pkg::REG_MAC_BASE, r.mac_base);
    write_reg(itmag_pkg::REG_COUNTER_BASE, r.counter_base);
    write_reg(itmag_pkg::REG_LOWER_NODE_BASE, r.lower_node_base);
    write_reg(itmag_pkg::REG_UPPER_NODE_BASE, r.upper_node_base);
    write_reg(itmag_pkg::REG_ROOT_ADDRESS, r.root_address);
    if (!spare_first) write_reg(REG_SPARE, junk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop the request, drain every owed fetch, then let the unit go quiet
  task automatic settle();
    access_bus.valid <= 1'b0;
    while (fetch_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : fetch_check
    itmag_pkg::result_t got, want;
    if (!rst && fetch_bus.valid && fetch_bus.ready) begin
      got.meta_address = fetch_bus.meta_address;
      got.meta_kind    = fetch_bus.meta_kind;
      got.out_of_range = fetch_bus.out_of_range;
      got.last_of_run  = fetch_bus.last_of_run;
      results_seen++;
      if (fetch_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected fetch addr=%h kind=%0d oor=%b last=%b", $time,
                 got.meta_address, got.meta_kind, got.out_of_range, got.last_of_run);
      end else begin
        want = fetch_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: fetch mismatch expected addr=%h kind=%0d oor=%b last=%b", $time,
                   want.meta_address, want.meta_kind, want.out_of_range, want.last_of_run);
          $display("%0t:                  actual addr=%h kind=%0d oor=%b last=%b", $time,
                   got.meta_address, got.meta_kind, got.out_of_range, got.last_of_run);
        end
      end
    end
  end

  // Receiver back-pressure: bursts of ready, sometimes very long ones
  initial begin : fetch_sink
    int on_len, off_len;
    fetch_bus.ready <= 1'b0;
    forever begin
      on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      off_len = pick_gap(1'b0);
      fetch_bus.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (off_len != 0) begin
        fetch_bus.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    itmag_pkg::result_t none;
    int                 n, random_left, cur_preset, directed;
    none = '0;
    access_bus.valid        <= 1'b0;
    access_bus.data_address <= '0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.index           <= itmag_pkg::REG_DATA_START;
    cfg_bus.data            <= '0;
    regs = '0;

    presets[0] = '0;
    presets[1] = make_regs(48'h0, 48'h20_0000, 48'h20_0000, 48'h24_0000,
                           48'h24_8000, 48'h24_9000, 48'h24_9200);
    // empty counter level, root right above the first counter, upper level empty
    presets[2] = make_regs(48'h1000, 48'h40_0000, 48'h40_0000, 48'h50_0000,
                           48'h50_0000, 48'h50_2000, 48'h50_0040);
    presets[3] = make_regs(48'h0, ALL_ONES, ALL_ONES, 48'hFFFF_FFFF_F000,
                           48'hFFFF_FFFF_F800, 48'hFFFF_FFFF_FFC0, ALL_ONES);

    add_row(0, 48'h0, 1'b1);
    add_row(0, ALL_ONES, 1'b1);
    add_row(1, 48'h0, 1'b0);
    add_row(1, 48'h1F_FFFF, 1'b0);
    add_row(1, 48'h20_0000, 1'b1);
    add_row(1, 48'h12_3456, 1'b0);
    add_row(1, 48'h7FF, 1'b0);
    add_row(1, 48'h0F_F000, 1'b0);
    add_row(2, 48'hFFF, 1'b1);
    add_row(2, 48'h1000, 1'b0);
    add_row(2, 48'h1FFF, 1'b0);
    add_row(2, 48'h2000, 1'b0);
    add_row(2, 48'h3F_FFFF, 1'b0);
    add_row(2, 48'h40_0000, 1'b1);
    add_row(3, 48'h0, 1'b0);
    add_row(3, ALL_ONES, 1'b1);
    add_row(3, ALL_ONES - 1, 1'b0);
    add_row(3, 48'h8000_0000_0000, 1'b0);
    add_row(3, 48'h5555_5555_5555, 1'b0);
    add_row(3, 48'hAAAA_AAAA_AAAA, 1'b0);
    add_row(3, 48'hFFF, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_preset = 0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].preset != cur_preset) begin
        settle();
        program_regs(presets[stim_rows[i].preset]);
        cur_preset = stim_rows[i].preset;
        phases++;
      end
      send_access(stim_rows[i].addr, stim_rows[i].typed, stim_rows[i].want);
    end
    directed = items_sent;

    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      n = $urandom_range(15, 45);
      if (n > random_left) n = random_left;
      settle();
      program_regs(random_layout());
      quiet = ($urandom_range(0, 3) == 0);
      repeat (n) send_access(pick_addr(), 1'b0, none);
      random_left -= n;
      phases++;
    end
    settle();

    $display("Ran %0d data addresses (%0d directed) over %0d register settings",
             items_sent, directed, phases);
    $display("Checked %0d metadata fetches, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("PASS integrity_tree_metadata_addr_gen_unit");
    end else begin
      $display("FAIL integrity_tree_metadata_addr_gen_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d fetches still owed", fetch_due.size());
    $display("FAIL integrity_tree_metadata_addr_gen_unit");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/itmag_pkg.sv
rtl/itmag_ifs.sv
rtl/itmag_step.sv
rtl/integrity_tree_metadata_addr_gen_unit.sv
rtl/itmag_checker.sv
test/integrity_tree_metadata_addr_gen_unit_tb.sv
